// ----- src/ldf_pkg.sv -----
// shared types and constants for the length prefix deframer
// no dependencies; compile first

package ldf_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 32;
  localparam int unsigned PrefixW  = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [PrefixW-1:0] PrefixMin   = PrefixW'(1);
  localparam logic [PrefixW-1:0] PrefixMax   = PrefixW'(4);
  localparam logic [PrefixW-1:0] PrefixReset = PrefixW'(2);
  localparam logic [LenW-1:0]    MaxLenReset = LenW'(65536);

  typedef enum logic [2:0] {
    KIND_PREFIX  = 3'd0,
    KIND_PAYLOAD = 3'd1,
    KIND_EMPTY   = 3'd2,
    KIND_SMALL   = 3'd3,
    KIND_BIG     = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_SMALL = 2'd1,
    ERR_BIG   = 2'd2
  } err_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PREFIX_BYTES      = 2'd0,
    CFG_MAX_MESSAGE_BYTES = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [PrefixW-1:0] prefix_len;
    logic [LenW-1:0]    max_len;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    kind_e            kind;
    logic             last;
    logic [LenW-1:0]  message_length;
  } result_t;

  typedef struct packed {
    err_e err;
  } status_t;

endpackage

// ----- src/ldf_if.sv -----
// byte input and result output channel interfaces
// depends on ldf_pkg

interface ldf_in_if import ldf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface ldf_out_if import ldf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] payload_byte;
  kind_e            kind;
  logic             last;
  logic [LenW-1:0]  message_length;

  modport source (output valid, output payload_byte, output kind, output last,
                  output message_length, input ready);
  modport sink   (input valid, input payload_byte, input kind, input last,
                  input message_length, output ready);
endinterface

// ----- src/ldf_cfg_regs.sv -----
// configuration registers with prefix size clamping
// depends on ldf_pkg

module ldf_cfg_regs import ldf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  logic [PrefixW-1:0] prefix_q, prefix_d;
  logic [LenW-1:0]    max_len_q, max_len_d;

  always_comb begin
    prefix_d  = prefix_q;
    max_len_d = max_len_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PREFIX_BYTES:      prefix_d  = cfg_data_i[PrefixW-1:0];
        CFG_MAX_MESSAGE_BYTES: max_len_d = cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q  <= PrefixReset;
      max_len_q <= MaxLenReset;
    end else begin
      prefix_q  <= prefix_d;
      max_len_q <= max_len_d;
    end
  end

  always_comb begin
    if (prefix_q < PrefixMin) begin
      cfg_o.prefix_len = PrefixMin;
    end else if (prefix_q > PrefixMax) begin
      cfg_o.prefix_len = PrefixMax;
    end else begin
      cfg_o.prefix_len = prefix_q;
    end
    cfg_o.max_len = max_len_q;
  end

endmodule

// ----- src/ldf_in_stage.sv -----
// input register for received bytes
// depends on ldf_pkg and ldf_in_if

module ldf_in_stage import ldf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  ldf_in_if.sink in_i,
  output item_t item_o,
  input  logic  item_ready_i
);

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q, byte_d;
  logic             load;

  assign in_i.ready = !valid_q || item_ready_i;
  assign load       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (load) begin
      valid_d = 1'b1;
      byte_d  = in_i.data_byte;
    end else if (item_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign item_o.valid     = valid_q;
  assign item_o.data_byte = byte_q;

endmodule

// ----- src/ldf_parser.sv -----
// message state, length assembly and checks, and result register
// depends on ldf_pkg and ldf_out_if

module ldf_parser import ldf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  item_t      item_i,
  output logic       item_ready_o,
  ldf_out_if.source  out_o,
  output status_t    status_o
);

  logic [LenW-1:0] seen_q, seen_d;
  logic [LenW-1:0] accum_q, accum_d;
  err_e            err_q, err_d;
  logic            out_valid_q, out_valid_d;
  result_t         res_q, res_d;

  logic            step;
  logic [LenW-1:0] p32;
  logic [LenW-1:0] accum_new;
  logic [LenW-1:0] seen_inc;
  logic [LenW-1:0] seen_sat;
  logic [LenW-1:0] pay_len;

  assign item_ready_o = !out_valid_q || out_o.ready;
  assign step         = item_i.valid && item_ready_o;

  assign p32       = LenW'(cfg_i.prefix_len);
  assign accum_new = accum_q | (LenW'(item_i.data_byte) << {seen_q[1:0], 3'b000});
  assign seen_inc  = seen_q + LenW'(1);
  assign seen_sat  = (seen_q == '1) ? seen_q : seen_inc;
  assign pay_len   = (accum_q >= p32) ? (accum_q - p32) : '0;

  always_comb begin
    seen_d      = seen_q;
    accum_d     = accum_q;
    err_d       = err_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (step) begin
      out_valid_d          = 1'b1;
      res_d.payload_byte   = '0;
      res_d.last           = 1'b0;
      res_d.message_length = '0;
      res_d.kind           = KIND_PREFIX;
      if (err_q == ERR_SMALL) begin
        res_d.kind = KIND_SMALL;
      end else if (err_q != ERR_NONE) begin
        res_d.kind = KIND_BIG;
      end else if (seen_q < p32) begin
        accum_d = accum_new;
        seen_d  = seen_inc;
        if (seen_inc >= p32) begin
          if (accum_new < p32) begin
            err_d      = ERR_SMALL;
            res_d.kind = KIND_SMALL;
          end else if (accum_new > cfg_i.max_len) begin
            err_d      = ERR_BIG;
            res_d.kind = KIND_BIG;
          end else if (accum_new == p32) begin
            seen_d     = '0;
            accum_d    = '0;
            res_d.kind = KIND_EMPTY;
            res_d.last = 1'b1;
          end else begin
            res_d.message_length = accum_new - p32;
          end
        end
      end else begin
        seen_d               = seen_sat;
        res_d.kind           = KIND_PAYLOAD;
        res_d.payload_byte   = item_i.data_byte;
        res_d.message_length = pay_len;
        if (seen_sat >= accum_q) begin
          res_d.last = 1'b1;
          seen_d     = '0;
          accum_d    = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      accum_q     <= '0;
      err_q       <= ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      seen_q      <= seen_d;
      accum_q     <= accum_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.payload_byte   = res_q.payload_byte;
  assign out_o.kind           = res_q.kind;
  assign out_o.last           = res_q.last;
  assign out_o.message_length = res_q.message_length;

  assign status_o.err = err_q;

endmodule

// ----- src/length_prefix_deframer_top.sv -----
// top level of the length prefix deframer
// depends on ldf_pkg, ldf_if, ldf_cfg_regs, ldf_in_stage and ldf_parser

// Splits a byte stream into messages with a little-endian length prefix of
// 1 to 4 bytes, the length counting the prefix. Each byte taken gives
// exactly one result, through an input register, then the length assembly
// and checks into the result register. A new byte is taken every cycle
// while the result side keeps up. Errors stick until reset.

module length_prefix_deframer_top import ldf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  ldf_in_if.sink              in_i,
  ldf_out_if.source           out_o
);

  cfg_t    cfg;
  item_t   item;
  logic    item_ready;
  status_t status;

  ldf_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ldf_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_o       (item),
    .item_ready_i (item_ready)
  );

  ldf_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_i       (item),
    .item_ready_o (item_ready),
    .out_o        (out_o),
    .status_o     (status)
  );

`ifndef SYNTH
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.err != ERR_NONE |=> status.err == $past(status.err))
    else $error("error code changed after being raised");

  a_err_result_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.kind == KIND_SMALL || out_o.kind == KIND_BIG)
      |-> !out_o.last && out_o.message_length == '0 && out_o.payload_byte == '0)
    else $error("error result carries data");

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.last |-> out_o.kind == KIND_PAYLOAD || out_o.kind == KIND_EMPTY)
    else $error("message end on a non-completing result");

  a_err_no_message: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.err == ERR_NONE ##1 status.err != ERR_NONE
      |-> out_o.valid && (out_o.kind == KIND_SMALL || out_o.kind == KIND_BIG))
    else $error("error raised without an error result");
`endif

endmodule
